// ----- rtl/nlp_pkg.sv -----
// nlp_pkg: shared types and character constants for the numeric literal parser
package nlp_pkg;

    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned MEM_SIZE_W = 33;

    localparam logic [MEM_SIZE_W-1:0] MEM_SIZE_RESET = 33'd65536;

    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;

    localparam logic [2:0] POS_MAX = 3'd7;

    typedef enum logic [1:0] {
        KIND_INVALID = 2'd0,
        KIND_DEC     = 2'd1,
        KIND_HEX     = 2'd2,
        KIND_MEM     = 2'd3
    } t_kind;

    // token snapshot handed from the scanner to the output stage
    typedef struct packed {
        logic               valid;
        t_kind              kind;
        logic               negate;
        logic               mem_ref;
        logic [VALUE_W-1:0] raw;
    } t_scan;

endpackage

// ----- rtl/nlp_ifs.sv -----
// nlp_ifs: character, result and configuration channel interfaces
interface nlp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink (input valid, input ch, input last, output ready);
endinterface

interface nlp_result_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;
    nlp_pkg::t_kind     kind;
    logic               address_fault;

    modport source (output valid, output value, output kind, output address_fault, input ready);
    modport sink (input valid, input value, input kind, input address_fault, output ready);
endinterface

interface nlp_cfg_if;
    logic        valid;
    logic        ready;
    logic [32:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/nlp_scan.sv -----
// nlp_scan: per-character token state and classification snapshot
module nlp_scan (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_ch,
    input  logic           i_last,
    input  logic           i_take,
    output logic           o_ready,
    output nlp_pkg::t_scan o_scan
);

    logic [2:0]  r_pos,       n_pos;
    logic        r_bracketed, n_bracketed;
    logic        r_negative,  n_negative;
    logic        r_dec_ok,    n_dec_ok;
    logic        r_hex_ok,    n_hex_ok;
    logic [63:0] r_dec_acc,   n_dec_acc;
    logic [63:0] r_hex_acc,   n_hex_acc;

    nlp_pkg::t_scan r_scan, n_scan;

    logic       adv;
    logic       accept;
    logic       is_dec;
    logic       is_lhex;
    logic       open_brk;
    logic       feed;
    logic       closed;
    logic       brk;
    logic       long_enough;
    logic [2:0] num_pos;
    logic [3:0] dig;

    assign adv     = !r_scan.valid || i_take;
    assign accept  = i_valid && adv;
    assign o_ready = adv;
    assign o_scan  = r_scan;

    always_comb begin
        n_pos       = r_pos;
        n_bracketed = r_bracketed;
        n_negative  = r_negative;
        n_dec_ok    = r_dec_ok;
        n_hex_ok    = r_hex_ok;
        n_dec_acc   = r_dec_acc;
        n_hex_acc   = r_hex_acc;
        n_scan      = r_scan;

        is_dec   = (i_ch >= nlp_pkg::CH_ZERO) && (i_ch <= nlp_pkg::CH_NINE);
        is_lhex  = (i_ch >= nlp_pkg::CH_A) && (i_ch <= nlp_pkg::CH_F);
        open_brk = (r_pos == 3'd0) && (i_ch == nlp_pkg::CH_LBRACK);
        feed     = !open_brk && !(r_bracketed && i_last);
        num_pos  = r_bracketed ? 3'(r_pos - 3'd1) : r_pos;
        dig      = is_dec ? i_ch[3:0] : 4'(i_ch[3:0] + 4'd9);

        if (open_brk) begin
            n_bracketed = 1'b1;
        end

        if (feed) begin
            if ((num_pos == 3'd0) && (i_ch == nlp_pkg::CH_MINUS)) begin
                n_negative = 1'b1;
            end else if (is_dec) begin
                n_dec_acc = {r_dec_acc[60:0], 3'b000} + {r_dec_acc[62:0], 1'b0}
                          + {60'd0, dig};
            end else begin
                n_dec_ok = 1'b0;
            end

            if (num_pos == 3'd0) begin
                if (i_ch != nlp_pkg::CH_ZERO) begin
                    n_hex_ok = 1'b0;
                end
            end else if (num_pos == 3'd1) begin
                if (i_ch != nlp_pkg::CH_X) begin
                    n_hex_ok = 1'b0;
                end
            end else if (is_dec || is_lhex) begin
                n_hex_acc = {r_hex_acc[59:0], dig};
            end else begin
                n_hex_ok = 1'b0;
            end
        end

        // classification on the final character
        closed      = r_bracketed && (i_ch == nlp_pkg::CH_RBRACK) && (r_pos >= 3'd2);
        brk         = r_bracketed || open_brk;
        long_enough = brk ? (r_pos >= 3'd4) : (r_pos >= 3'd2);

        n_scan.valid   = 1'b0;
        n_scan.kind    = nlp_pkg::KIND_INVALID;
        n_scan.negate  = 1'b0;
        n_scan.mem_ref = 1'b0;
        n_scan.raw     = '0;
        if (accept && i_last) begin
            n_scan.valid = 1'b1;
            if (!brk || closed) begin
                if (n_dec_ok) begin
                    n_scan.kind   = nlp_pkg::KIND_DEC;
                    n_scan.negate = n_negative;
                    n_scan.raw    = n_dec_acc;
                end else if (n_hex_ok && long_enough) begin
                    n_scan.kind = nlp_pkg::KIND_HEX;
                    n_scan.raw  = n_hex_acc;
                end
                if (brk && (n_dec_ok || (n_hex_ok && long_enough))) begin
                    n_scan.kind    = nlp_pkg::KIND_MEM;
                    n_scan.mem_ref = 1'b1;
                end
            end
        end else if (!adv) begin
            n_scan = r_scan;
        end

        if (i_last) begin
            n_pos       = 3'd0;
            n_bracketed = 1'b0;
            n_negative  = 1'b0;
            n_dec_ok    = 1'b1;
            n_hex_ok    = 1'b1;
            n_dec_acc   = '0;
            n_hex_acc   = '0;
        end else if (r_pos != nlp_pkg::POS_MAX) begin
            n_pos = 3'(r_pos + 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 3'd0;
            r_bracketed <= 1'b0;
            r_negative  <= 1'b0;
            r_dec_ok    <= 1'b1;
            r_hex_ok    <= 1'b1;
            r_dec_acc   <= '0;
            r_hex_acc   <= '0;
            r_scan      <= '0;
        end else begin
            if (accept) begin
                r_pos       <= n_pos;
                r_bracketed <= n_bracketed;
                r_negative  <= n_negative;
                r_dec_ok    <= n_dec_ok;
                r_hex_ok    <= n_hex_ok;
                r_dec_acc   <= n_dec_acc;
                r_hex_acc   <= n_hex_acc;
            end
            r_scan <= n_scan;
        end
    end

endmodule

// ----- rtl/numeric_literal_parser.sv -----
// numeric_literal_parser: top level of the decimal/hex/memory-reference literal parser
//
// i_char carries one token character per request (ch, last). The block takes
// one character every cycle while ready. Decimal, hex and bracketed memory
// references are recognized; a request with last set produces one result on
// o_result (value, kind, address_fault); other characters produce none.
// i_cfg writes the 33-bit memory size used for the address fault check; it is
// always ready. The user must write it only while no token is in flight; the
// block itself does not enforce this. A final character loads the scanner
// snapshot register, then the output register loads from it and applies the
// sign fix-up and the address compare.
// Throughput: one character per cycle while i_char.ready is high; the
// multiply-by-ten/sixteen accumulate in the scanner is combinational.
// Reset clears the token state, drops any pending result and sets the memory
// size to 65536. When the receiver stalls, up to two results are held (output
// register and snapshot); i_char.ready falls only when both are full.
module numeric_literal_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    nlp_cfg_if.sink      i_cfg,
    nlp_char_if.sink     i_char,
    nlp_result_if.source o_result
);

    nlp_pkg::t_scan scan;

    logic [nlp_pkg::MEM_SIZE_W-1:0] r_mem_size;
    logic                           r_out_valid, n_out_valid;
    logic [nlp_pkg::VALUE_W-1:0]    r_value, n_value;
    nlp_pkg::t_kind                 r_kind, n_kind;
    logic                           r_fault, n_fault;

    logic                        take;
    logic [nlp_pkg::VALUE_W-1:0] signed_val;

    assign take = !r_out_valid || o_result.ready;

    nlp_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_char.valid),
        .i_ch    (i_char.ch),
        .i_last  (i_char.last),
        .i_take  (take),
        .o_ready (i_char.ready),
        .o_scan  (scan)
    );

    assign i_cfg.ready = 1'b1;

    always_comb begin
        signed_val  = scan.negate ? 64'(64'd0 - scan.raw) : scan.raw;
        n_out_valid = r_out_valid;
        n_value     = r_value;
        n_kind      = r_kind;
        n_fault     = r_fault;
        if (take) begin
            n_out_valid = scan.valid;
            n_kind      = scan.kind;
            if (scan.mem_ref) begin
                n_value = {32'd0, signed_val[nlp_pkg::ADDR_W-1:0]};
                n_fault = ({1'b0, signed_val[nlp_pkg::ADDR_W-1:0]} >= r_mem_size);
            end else begin
                n_value = signed_val;
                n_fault = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_size  <= nlp_pkg::MEM_SIZE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_mem_size <= i_cfg.data;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_kind  <= n_kind;
        r_fault <= n_fault;
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.value         = $signed(r_value);
    assign o_result.kind          = r_kind;
    assign o_result.address_fault = r_fault;

endmodule

// ----- rtl/nlp_checker.sv -----
// nlp_checker: port-level assertions for the numeric literal parser
module nlp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [63:0] i_value,
    input logic [1:0]         i_kind,
    input logic               i_fault
);

    // held result while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_value)
            && $stable(i_kind) && $stable(i_fault))
        else $error("result changed under stall");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == nlp_pkg::KIND_INVALID) |-> (i_value == 64'sd0) && !i_fault)
        else $error("invalid token with nonzero value or fault");

    a_fault_mem_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_fault |-> (i_kind == nlp_pkg::KIND_MEM))
        else $error("fault on a non memory reference");

    a_mem_addr_32: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == nlp_pkg::KIND_MEM) |-> (i_value[63:32] == 32'd0))
        else $error("memory reference address wider than 32 bits");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

endmodule

bind numeric_literal_parser nlp_checker u_nlp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_char.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_value     (o_result.value),
    .i_kind      (o_result.kind),
    .i_fault     (o_result.address_fault)
);
